// ===== rtl/core/des_pkg.sv =====
// ----------------------------------------------------------------------------
// des_pkg: shared types and constants for the descending exchange sort unit
// Field widths of the request and result items, and the default list depth.
// ----------------------------------------------------------------------------
package des_pkg;

  localparam int unsigned KeyW              = 32;
  localparam int unsigned PosW              = 6;
  localparam int unsigned MaxEntriesDefault = 32;

  typedef struct packed {
    logic [KeyW-1:0] salary_key;
    logic            end_of_list;
  } in_item_t;

  typedef struct packed {
    logic [KeyW-1:0] sorted_key;
    logic [PosW-1:0] origin_position;
    logic            final_result;
  } out_item_t;

endpackage

// ===== rtl/core/des_stream_if.sv =====
// ----------------------------------------------------------------------------
// des_stream_if: valid/ready stream channel
// Carries one payload item per handshake from a source to a sink.
// ----------------------------------------------------------------------------
interface des_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/core/descending_exchange_sort_unit.sv =====
// ----------------------------------------------------------------------------
// descending_exchange_sort_unit: list loader, exchange sorter and emitter
// After the closing request the sort holds each entry i and compares it with
//   every entry j, one compare per cycle, then writes it back. Results leave
//   one at a time, held while the output register is full; loading restarts
//   as soon as the final result sits in the output register.
// Reset: asynchronous, empties the list and drops any pending result.
// ----------------------------------------------------------------------------
module descending_exchange_sort_unit #(
  parameter int unsigned MaxEntries = des_pkg::MaxEntriesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  des_stream_if.sink   in_i,
  des_stream_if.source out_o
);

  localparam int unsigned AW   = $clog2(MaxEntries);
  localparam int unsigned CntW = $clog2(MaxEntries + 1);

  localparam logic [2:0] StLoad = 3'd0;
  localparam logic [2:0] StRdI  = 3'd1;
  localparam logic [2:0] StCur  = 3'd2;
  localparam logic [2:0] StCmp  = 3'd3;
  localparam logic [2:0] StWbI  = 3'd4;
  localparam logic [2:0] StERd  = 3'd5;
  localparam logic [2:0] StEOut = 3'd6;

  typedef struct packed {
    logic [des_pkg::KeyW-1:0] key;
    logic [AW-1:0]            pos;
  } entry_t;

  logic [2:0]         state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    n_q, n_d;
  logic [AW-1:0]      i_q, i_d;
  logic [AW-1:0]      j_q, j_d;
  logic [AW-1:0]      r_q, r_d;
  entry_t             cur_q, cur_d;
  logic               out_valid_q, out_valid_d;
  des_pkg::out_item_t out_q, out_d;

  entry_t             mem_q [MaxEntries];
  entry_t             rdata_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  entry_t             mem_wdata;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      last_idx;
  logic [CntW-1:0]    n_minus_one;

  assign n_minus_one = n_q - CntW'(1);
  assign last_idx    = n_minus_one[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    r_d         = r_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = i_q;
    mem_wdata   = cur_q;
    rd_addr     = i_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StLoad: begin
        if (in_i.valid) begin
          if (cnt_q < CntW'(MaxEntries)) begin
            mem_we        = 1'b1;
            mem_waddr     = cnt_q[AW-1:0];
            mem_wdata.key = in_i.payload.salary_key;
            mem_wdata.pos = cnt_q[AW-1:0];
            cnt_d         = cnt_q + CntW'(1);
          end
          if (in_i.payload.end_of_list) begin
            n_d     = (cnt_q < CntW'(MaxEntries)) ? cnt_q + CntW'(1) : cnt_q;
            i_d     = '0;
            state_d = StRdI;
          end
        end
      end
      StRdI: begin
        rd_addr = i_q;
        state_d = StCur;
      end
      StCur: begin
        cur_d   = rdata_q;
        rd_addr = '0;
        j_d     = '0;
        state_d = StCmp;
      end
      StCmp: begin
        rd_addr = j_q + AW'(1);
        j_d     = j_q + AW'(1);
        // swap the held entry i with entry j when key[j] < key[i]
        if (j_q != i_q && rdata_q.key < cur_q.key) begin
          mem_we    = 1'b1;
          mem_waddr = j_q;
          mem_wdata = cur_q;
          cur_d     = rdata_q;
        end
        if (j_q == last_idx) begin
          state_d = StWbI;
        end
      end
      StWbI: begin
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = cur_q;
        rd_addr   = i_q + AW'(1);
        i_d       = i_q + AW'(1);
        if (i_q == last_idx) begin
          r_d     = '0;
          state_d = StERd;
        end else begin
          state_d = StCur;
        end
      end
      StERd: begin
        rd_addr = r_q;
        state_d = StEOut;
      end
      StEOut: begin
        rd_addr = r_q;
        if (!out_valid_q || out_o.ready) begin
          out_valid_d           = 1'b1;
          out_d.sorted_key      = rdata_q.key;
          out_d.origin_position = des_pkg::PosW'(rdata_q.pos);
          out_d.final_result    = (r_q == last_idx);
          if (r_q == last_idx) begin
            cnt_d   = '0;
            state_d = StLoad;
          end else begin
            r_d     = r_q + AW'(1);
            state_d = StERd;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    i_q   <= i_d;
    j_q   <= j_d;
    r_q   <= r_d;
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign in_i.ready    = (state_q == StLoad);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxEntries))
    else $error("list count exceeds depth");

  a_close_starts_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.payload.end_of_list |=> state_q == StRdI)
    else $error("closing request did not start the sort");

  a_j_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StCmp |-> CntW'(j_q) < n_q)
    else $error("compare index beyond list");

  a_list_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StLoad |-> n_q != '0)
    else $error("sorting an empty list");
`endif

endmodule

// ===== verif/descending_exchange_sort_checker.sv =====
// ----------------------------------------------------------------------------
// descending_exchange_sort_checker: rank predictor and result comparator
// Watches the request and result channels. Each accepted request, up to the
// depth, is copied into a local list. A closing request ranks that list with
// the same double-loop exchange sort and queues the ranked entries. Each
// accepted result is compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module descending_exchange_sort_checker
  import des_pkg::*;
#(
  parameter int unsigned MaxEntries = des_pkg::MaxEntriesDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  des_stream_if req_i,
  des_stream_if rsp_i,
  output int    fail_count_o,
  output int    pending_o
);

  logic [KeyW-1:0] held_key [MaxEntries];
  logic [PosW-1:0] held_pos [MaxEntries];
  int unsigned     held_count;
  out_item_t       ranked_q [$];
  int              fail_count;

  initial begin
    held_count   = 0;
    fail_count   = 0;
    fail_count_o = 0;
    pending_o    = 0;
    for (int e = 0; e < MaxEntries; e++) begin
      held_key[e] = '0;
      held_pos[e] = '0;
    end
  end

  task automatic rank_held_list();
    logic [KeyW-1:0] k;
    logic [PosW-1:0] p;
    out_item_t       r;
    for (int unsigned i = 0; i < held_count; i++) begin
      for (int unsigned j = 0; j < held_count; j++) begin
        if (held_key[j] < held_key[i]) begin
          k           = held_key[j];
          p           = held_pos[j];
          held_key[j] = held_key[i];
          held_pos[j] = held_pos[i];
          held_key[i] = k;
          held_pos[i] = p;
        end
      end
    end
    for (int unsigned n = 0; n < held_count; n++) begin
      r.sorted_key      = held_key[n];
      r.origin_position = held_pos[n];
      r.final_result    = (n + 1 == held_count);
      ranked_q.push_back(r);
    end
    held_count = 0;
  endtask

  task automatic check_result(input out_item_t act);
    out_item_t exp;
    if (ranked_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual key %h pos %0d last %0b",
               $time, act.sorted_key, act.origin_position, act.final_result);
      fail_count++;
      return;
    end
    exp = ranked_q.pop_front();
    if (act.sorted_key !== exp.sorted_key) begin
      $display("%0t: sorted_key mismatch, expected %h, actual %h",
               $time, exp.sorted_key, act.sorted_key);
      fail_count++;
    end
    if (act.origin_position !== exp.origin_position) begin
      $display("%0t: origin_position mismatch, expected %0d, actual %0d",
               $time, exp.origin_position, act.origin_position);
      fail_count++;
    end
    if (act.final_result !== exp.final_result) begin
      $display("%0t: final_result mismatch, expected %0b, actual %0b",
               $time, exp.final_result, act.final_result);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_i.valid && rsp_i.ready) check_result(rsp_i.payload);
      if (req_i.valid && req_i.ready) begin
        if (held_count < MaxEntries) begin
          held_key[held_count] = req_i.payload.salary_key;
          held_pos[held_count] = held_count[PosW-1:0];
          held_count++;
        end
        if (req_i.payload.end_of_list) rank_held_list();
      end
    end
    pending_o    <= ranked_q.size();
    fail_count_o <= fail_count + ranked_q.size() * 0;
  end

  final begin
    if (ranked_q.size() != 0)
      $display("%0t: %0d ranked entries never arrived, expected %h, actual none",
               $time, ranked_q.size(), ranked_q[0].sorted_key);
  end

endmodule

// ===== verif/descending_exchange_sort_unit_tb.sv =====
// ----------------------------------------------------------------------------
// descending_exchange_sort_unit_tb: stimulus and verdict for the sort unit
// Loads directed lists (single entries, extreme keys, ties, ascending and
// descending runs), then random lists of mixed length, including lists that
// overflow the entry store. Sender gaps and receiver stalls change by phase.
// The checker predicts and compares; this top reports the result.
// ----------------------------------------------------------------------------
module descending_exchange_sort_unit_tb;
  import des_pkg::*;

  localparam int unsigned ListDepth  = des_pkg::MaxEntriesDefault;
  localparam int          TargetLoad = 460;
  localparam int          CycleLimit = 600000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   gap_pct;
  int   stall_pct;
  int   loaded_items;
  int   cycle_count;

  logic [KeyW-1:0] list_keys [$];

  des_stream_if #(.payload_t(in_item_t))  req_if ();
  des_stream_if #(.payload_t(out_item_t)) rsp_if ();

  descending_exchange_sort_unit #(
    .MaxEntries(ListDepth)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  descending_exchange_sort_checker #(
    .MaxEntries(ListDepth)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    gap_pct        = 34;
    stall_pct      = 81;
    cycle_count    = 0;
  end

  always @(posedge clk) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("descending_exchange_sort_unit test failed");
      $finish;
    end
  end

  task automatic push_request(input logic [KeyW-1:0] key, input logic last);
    while ($urandom_range(0, 99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid              <= 1'b1;
    req_if.payload.salary_key  <= key;
    req_if.payload.end_of_list <= last;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic send_list();
    foreach (list_keys[n]) push_request(list_keys[n], n == list_keys.size() - 1);
    loaded_items += (list_keys.size() > ListDepth) ? ListDepth : list_keys.size();
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return KeyW'($urandom_range(0, 7));
      5:       return {8'hFF, 24'($urandom_range(0, 3))};
      default: return $urandom;
    endcase
  endfunction

  task automatic fill_random_list();
    int len;
    case ($urandom_range(0, 9))
      0:          len = $urandom_range(33, 40);
      1, 2:       len = $urandom_range(9, 32);
      default:    len = $urandom_range(1, 8);
    endcase
    list_keys.delete();
    repeat (len) list_keys.push_back(pick_key());
  endtask

  initial begin
    loaded_items = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    list_keys = '{32'hFFFF_FFFF};
    send_list();
    list_keys = '{32'h0000_0000};
    send_list();
    list_keys = '{32'h5, 32'h5, 32'hFFFF_FFFF, 32'h0, 32'h5};
    send_list();
    list_keys = '{32'h7, 32'h7, 32'h7};
    send_list();
    list_keys = '{32'h1, 32'h2, 32'h3, 32'h4};
    send_list();
    list_keys = '{32'h9, 32'h8, 32'h7};
    send_list();

    // overflow: closing request lands on a dropped key
    list_keys.delete();
    repeat (ListDepth + 1) list_keys.push_back(pick_key());
    send_list();
    drain_results();

    while (loaded_items < TargetLoad) begin
      if (loaded_items >= TargetLoad / 3 && gap_pct == 34) begin
        drain_results();
        gap_pct   = 81;
        stall_pct = 34;
      end else if (loaded_items >= 2 * TargetLoad / 3 && gap_pct == 81) begin
        drain_results();
        gap_pct   = 0;
        stall_pct = 0;
      end
      fill_random_list();
      send_list();
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("descending_exchange_sort_unit test passed");
    end else begin
      $display("descending_exchange_sort_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/des_pkg.sv
rtl/core/des_stream_if.sv
rtl/core/descending_exchange_sort_unit.sv
verif/descending_exchange_sort_checker.sv
verif/descending_exchange_sort_unit_tb.sv
